>>> hw/rtl/pidpi_pkg.sv
// Package for the positional/incremental PID controller.
// Holds configuration types, register indexes, reset values and stage controls.
// No dependencies.
`default_nettype none

package pidpi_pkg;

    localparam int CFG_DW  = 16;
    localparam int CFG_AW  = 3;
    localparam int MEAS_W  = 16;
    localparam int DRIVE_W = 16;
    localparam int TGT_W   = 15;
    localparam int GAIN_W  = 16;
    localparam int ERR_W   = 17;
    localparam int DIFF_W  = 18;
    localparam int INTEG_W = 24;
    localparam int PA_W    = GAIN_W + 1 + DIFF_W;
    localparam int PB_W    = GAIN_W + 1 + INTEG_W;
    localparam int SUM_W   = PB_W + 2;

    localparam logic [GAIN_W-1:0] RST_KP    = 16'd116;
    localparam logic [GAIN_W-1:0] RST_KI    = 16'd451;
    localparam logic [GAIN_W-1:0] RST_LIMIT = 16'd1000;

    typedef enum logic [CFG_AW-1:0] {
        REG_MODE       = 3'd0,
        REG_TARGET     = 3'd1,
        REG_KP         = 3'd2,
        REG_KI         = 3'd3,
        REG_KD         = 3'd4,
        REG_INTEG_LIM  = 3'd5,
        REG_OUT_LIM    = 3'd6
    } t_reg_idx;

    typedef enum logic {
        MODE_POSITIONAL  = 1'b0,
        MODE_INCREMENTAL = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [TGT_W-1:0]   target;
        logic [GAIN_W-1:0]  kp;
        logic [GAIN_W-1:0]  ki;
        logic [GAIN_W-1:0]  kd;
        logic [GAIN_W-1:0]  integ_lim;
        logic [GAIN_W-1:0]  out_lim;
    } t_cfg;

    // load enables: s0 input register, s1 result register and controller state
    typedef struct packed {
        logic s0;
        logic s1;
    } t_adv;

endpackage

`default_nettype wire

>>> hw/rtl/pidpi_dp.sv
// PID datapath: input register, then error, integral, gain products, sum and clamp.
// Holds previous error, integral and output value state.
// Depends on pidpi_pkg.
`default_nettype none

module pidpi_dp (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  pidpi_pkg::t_cfg                     i_cfg,
    input  pidpi_pkg::t_adv                     i_adv,
    input  wire signed [pidpi_pkg::MEAS_W-1:0]  i_measurement,
    output logic [pidpi_pkg::DRIVE_W-1:0]       o_drive
);

    logic signed [pidpi_pkg::MEAS_W-1:0]  r_meas;

    logic signed [pidpi_pkg::ERR_W-1:0]   r_prev_err;
    logic signed [pidpi_pkg::INTEG_W-1:0] r_integ;
    logic [pidpi_pkg::DRIVE_W-1:0]        r_out;

    logic signed [pidpi_pkg::ERR_W-1:0]   meas_x;
    logic signed [pidpi_pkg::ERR_W-1:0]   mag;
    logic signed [pidpi_pkg::INTEG_W-1:0] integ_mag;
    logic signed [pidpi_pkg::ERR_W-1:0]   n_err;
    logic signed [pidpi_pkg::DIFF_W-1:0]  n_diff;
    logic signed [pidpi_pkg::INTEG_W-1:0] n_integ;

    logic signed [pidpi_pkg::DIFF_W-1:0]  op_a;
    logic signed [pidpi_pkg::INTEG_W-1:0] op_b;
    logic signed [pidpi_pkg::GAIN_W:0]    kp_s;
    logic signed [pidpi_pkg::GAIN_W:0]    ki_s;
    logic signed [pidpi_pkg::GAIN_W:0]    kd_s;
    logic signed [pidpi_pkg::PA_W-1:0]    p_a;
    logic signed [pidpi_pkg::PB_W-1:0]    p_b;
    logic signed [pidpi_pkg::PA_W-1:0]    p_c;

    logic signed [pidpi_pkg::SUM_W-1:0]   sum;
    logic signed [pidpi_pkg::SUM_W-1:0]   base;
    logic signed [pidpi_pkg::SUM_W-1:0]   term_c;
    logic [pidpi_pkg::DRIVE_W-1:0]        n_out;

    // input register
    always_ff @(posedge i_clk) begin
        if (i_adv.s0) begin
            r_meas <= i_measurement;
        end
    end

    // magnitude, error, derivative difference, integral update
    always_comb begin
        meas_x    = pidpi_pkg::ERR_W'(r_meas);
        mag       = meas_x[pidpi_pkg::ERR_W-1] ? -meas_x : meas_x;
        n_err     = $signed({2'b00, i_cfg.target}) - mag;
        n_diff    = pidpi_pkg::DIFF_W'(n_err) - pidpi_pkg::DIFF_W'(r_prev_err);
        integ_mag = r_integ[pidpi_pkg::INTEG_W-1] ? -r_integ : r_integ;
        n_integ   = r_integ;
        if (i_cfg.mode == pidpi_pkg::MODE_POSITIONAL &&
            $unsigned(integ_mag) <
            {{(pidpi_pkg::INTEG_W-pidpi_pkg::GAIN_W){1'b0}}, i_cfg.integ_lim}) begin
            n_integ = r_integ + pidpi_pkg::INTEG_W'(n_err);
        end
    end

    // gain products
    always_comb begin
        kp_s = $signed({1'b0, i_cfg.kp});
        ki_s = $signed({1'b0, i_cfg.ki});
        kd_s = $signed({1'b0, i_cfg.kd});
        if (i_cfg.mode == pidpi_pkg::MODE_INCREMENTAL) begin
            op_a = n_diff;
            op_b = pidpi_pkg::INTEG_W'(n_err);
        end else begin
            op_a = pidpi_pkg::DIFF_W'(n_err);
            op_b = n_integ;
        end
        p_a = pidpi_pkg::PA_W'(kp_s) * pidpi_pkg::PA_W'(op_a);
        p_b = pidpi_pkg::PB_W'(ki_s) * pidpi_pkg::PB_W'(op_b);
        p_c = pidpi_pkg::PA_W'(kd_s) * pidpi_pkg::PA_W'(n_diff);
    end

    // sum and clamp to 0 .. out_lim
    always_comb begin
        if (i_cfg.mode == pidpi_pkg::MODE_INCREMENTAL) begin
            base   = $signed({{(pidpi_pkg::SUM_W-pidpi_pkg::DRIVE_W){1'b0}}, r_out});
            term_c = '0;
        end else begin
            base   = '0;
            term_c = pidpi_pkg::SUM_W'(p_c);
        end
        sum = base + pidpi_pkg::SUM_W'(p_a) + pidpi_pkg::SUM_W'(p_b) + term_c;
        if (sum[pidpi_pkg::SUM_W-1]) begin
            n_out = '0;
        end else if (sum >
            $signed({{(pidpi_pkg::SUM_W-pidpi_pkg::GAIN_W){1'b0}}, i_cfg.out_lim})) begin
            n_out = i_cfg.out_lim;
        end else begin
            n_out = sum[pidpi_pkg::DRIVE_W-1:0];
        end
    end

    // result register and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
            r_integ    <= '0;
            r_out      <= '0;
        end else if (i_adv.s1) begin
            r_prev_err <= n_err;
            r_integ    <= n_integ;
            r_out      <= n_out;
        end
    end

    assign o_drive = r_out;

endmodule

`default_nettype wire

>>> hw/rtl/pid_position_or_increment.sv
// Top level of the positional/incremental PID controller.
// The result register follows the input register; one transaction per cycle while the output is not stalled.
// Input register plus result register: output stall backs up through both, o_stall
// rises once both hold a transaction and i_stall is high.
// Synchronous active-low reset clears valids, controller state and loads
// configuration defaults. Depends on pidpi_pkg and pidpi_dp.
`default_nettype none

module pid_position_or_increment (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_wr_en,
    input  wire [pidpi_pkg::CFG_AW-1:0]         i_cfg_index,
    input  wire [pidpi_pkg::CFG_DW-1:0]         i_cfg_data,
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire signed [pidpi_pkg::MEAS_W-1:0]  i_measurement,
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic [pidpi_pkg::DRIVE_W-1:0]       o_drive
);

    pidpi_pkg::t_cfg r_cfg;
    pidpi_pkg::t_adv adv;

    logic r_v0;
    logic r_ovalid;
    logic rdy0;
    logic rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode      <= pidpi_pkg::MODE_POSITIONAL;
            r_cfg.target    <= '0;
            r_cfg.kp        <= pidpi_pkg::RST_KP;
            r_cfg.ki        <= pidpi_pkg::RST_KI;
            r_cfg.kd        <= '0;
            r_cfg.integ_lim <= pidpi_pkg::RST_LIMIT;
            r_cfg.out_lim   <= pidpi_pkg::RST_LIMIT;
        end else if (i_cfg_wr_en) begin
            unique case (pidpi_pkg::t_reg_idx'(i_cfg_index))
                pidpi_pkg::REG_MODE:      r_cfg.mode      <= pidpi_pkg::t_mode'(i_cfg_data[0]);
                pidpi_pkg::REG_TARGET:    r_cfg.target    <= i_cfg_data[pidpi_pkg::TGT_W-1:0];
                pidpi_pkg::REG_KP:        r_cfg.kp        <= i_cfg_data;
                pidpi_pkg::REG_KI:        r_cfg.ki        <= i_cfg_data;
                pidpi_pkg::REG_KD:        r_cfg.kd        <= i_cfg_data;
                pidpi_pkg::REG_INTEG_LIM: r_cfg.integ_lim <= i_cfg_data;
                pidpi_pkg::REG_OUT_LIM:   r_cfg.out_lim   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage advance, back to front
    always_comb begin
        rdy1   = !r_ovalid || !i_stall;
        adv.s1 = r_v0 && rdy1;
        rdy0   = !r_v0 || adv.s1;
        adv.s0 = i_valid && rdy0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (adv.s0) begin
                r_v0 <= 1'b1;
            end else if (adv.s1) begin
                r_v0 <= 1'b0;
            end
            if (adv.s1) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    pidpi_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_adv         (adv),
        .i_measurement (i_measurement),
        .o_drive       (o_drive)
    );

    assign o_stall = !rdy0;
    assign o_valid = r_ovalid;

endmodule

`default_nettype wire

>>> hw/rtl/pidpi_chk.sv
// Port-level checker for pid_position_or_increment, attached by bind.
// Depends on pidpi_pkg for port widths.
`default_nettype none

module pidpi_chk (
    input wire                                 i_clk,
    input wire                                 i_rst_n,
    input wire                                 i_cfg_wr_en,
    input wire [pidpi_pkg::CFG_AW-1:0]         i_cfg_index,
    input wire [pidpi_pkg::CFG_DW-1:0]         i_cfg_data,
    input wire                                 i_valid,
    input wire                                 o_stall,
    input wire signed [pidpi_pkg::MEAS_W-1:0]  i_measurement,
    input wire                                 o_valid,
    input wire                                 i_stall,
    input wire [pidpi_pkg::DRIVE_W-1:0]        o_drive
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_drive))
        else $error("result changed while stalled");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // with no result pending the input side is never held off
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output");

    // an accepted transaction reaches the result register when the output is not stalled
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall |=> o_valid)
        else $error("result missing after pipeline latency");

endmodule

bind pid_position_or_increment pidpi_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_wr_en   (i_cfg_wr_en),
    .i_cfg_index   (i_cfg_index),
    .i_cfg_data    (i_cfg_data),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_measurement (i_measurement),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_drive       (o_drive)
);

`default_nettype wire
